// ===== src/shfr_pkg.sv =====
// Shared types, codes and character helpers for the sync hex frame receiver.
`default_nettype none
package shfr_pkg;

  localparam int unsigned TdataBits  = 40;
  localparam int unsigned LengthBits = 24;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_FLAG  = 3'd1,
    ERR_NO_DIGITS = 3'd2,
    ERR_TOO_MANY  = 3'd3,
    ERR_OVER_LIM  = 3'd4,
    ERR_BAD_HEX   = 3'd5,
    ERR_NO_LF     = 3'd6
  } error_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            payload;
    logic                  mode_flag;
    logic [LengthBits-1:0] frame_length;
    logic                  last;
    error_e                error_code;
  } res_t;

  localparam logic [95:0] SyncPattern = 96'h73657269_616C2073_796E630A;
  localparam logic [7:0]  CharZero    = 8'h30;
  localparam logic [7:0]  CharOne     = 8'h31;
  localparam logic [7:0]  CharNine    = 8'h39;
  localparam logic [7:0]  CharLf      = 8'h0A;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/shfr_sync_detect.sv =====
// Sliding 12-character window and sync pattern match.
`default_nettype none
module shfr_sync_detect (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       beat_i,
  input  wire logic       hunting_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            found_o
);

  logic [95:0] win_q, win_d;
  logic [95:0] win_shift;

  always_comb begin
    win_shift = {win_q[87:0], rx_byte_i};
    found_o   = beat_i && hunting_i && (win_shift == shfr_pkg::SyncPattern);
    win_d     = win_q;
    if (beat_i && hunting_i) begin
      win_d = found_o ? 96'b0 : win_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 96'b0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/shfr_parser.sv =====
// Frame parser: flag, decimal length and hex payload decoding.
`default_nettype none
module shfr_parser #(
  parameter int unsigned MAX_DIGITS = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        beat_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        found_i,
  output logic             hunting_o,
  output logic             res_valid_o,
  output shfr_pkg::res_t   res_o
);

  localparam int unsigned DW = $clog2(MAX_DIGITS);
  localparam int unsigned LB = shfr_pkg::LengthBits;
  localparam logic [DW:0] MaxDig = (DW + 1)'(MAX_DIGITS);

  typedef enum logic [1:0] {PhHunt, PhFlag, PhLen, PhData} phase_e;

  phase_e          phase_q, phase_d;
  logic            flag_q, flag_d;
  logic [LB-1:0]   acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [DW-1:0]   cnt_q, cnt_d;
  logic [LB-1:0]   left_q, left_d;
  logic [3:0]      hi_q, hi_d;
  logic [3:0]      lo_q, lo_d;
  logic [1:0]      pos_q, pos_d;
  logic [23:0]     limit_q;

  logic            is_digit;
  logic [LB+3:0]   acc_next;
  logic [32:0]     acc_ext;
  logic [4:0]      hex;
  logic            do_clear;

  assign hunting_o = (phase_q == PhHunt);

  always_comb begin
    phase_d     = phase_q;
    flag_d      = flag_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    pos_d       = pos_q;
    do_clear    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    is_digit    = (rx_byte_i >= shfr_pkg::CharZero) && (rx_byte_i <= shfr_pkg::CharNine);
    acc_next    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (LB + 4)'(rx_byte_i[3:0]);
    acc_ext     = 33'(acc_q);
    hex         = shfr_pkg::hex_decode(rx_byte_i);

    if (beat_i) begin
      case (phase_q)
        PhHunt: begin
          if (found_i) begin
            do_clear = 1'b1;
          end
        end
        PhFlag: begin
          if (rx_byte_i == shfr_pkg::CharZero || rx_byte_i == shfr_pkg::CharOne) begin
            flag_d  = rx_byte_i[0];
            phase_d = PhLen;
          end else begin
            res_valid_o      = 1'b1;
            res_o.kind       = shfr_pkg::KIND_ERROR;
            res_o.error_code = shfr_pkg::ERR_BAD_FLAG;
            do_clear         = 1'b1;
          end
        end
        PhLen: begin
          if (is_digit) begin
            if (({1'b0, cnt_q} + 1'b1) >= MaxDig) begin
              res_valid_o      = 1'b1;
              res_o.kind       = shfr_pkg::KIND_ERROR;
              res_o.error_code = shfr_pkg::ERR_TOO_MANY;
              do_clear         = 1'b1;
            end else begin
              cnt_d = cnt_q + 1'b1;
              if (ovf_q || (acc_next[LB+3:LB] != 4'b0)) begin
                ovf_d = 1'b1;
                acc_d = '1;
              end else begin
                acc_d = acc_next[LB-1:0];
              end
            end
          end else if (cnt_q == '0 || (!ovf_q && acc_q == '0)) begin
            res_valid_o      = 1'b1;
            res_o.kind       = shfr_pkg::KIND_ERROR;
            res_o.error_code = shfr_pkg::ERR_NO_DIGITS;
            do_clear         = 1'b1;
          end else if (ovf_q || acc_ext > 33'(limit_q)) begin
            res_valid_o      = 1'b1;
            res_o.kind       = shfr_pkg::KIND_ERROR;
            res_o.error_code = shfr_pkg::ERR_OVER_LIM;
            do_clear         = 1'b1;
          end else begin
            res_valid_o        = 1'b1;
            res_o.kind         = shfr_pkg::KIND_HEADER;
            res_o.mode_flag    = flag_q;
            res_o.frame_length = acc_ext[LB-1:0];
            left_d             = acc_q;
            pos_d              = 2'd0;
            phase_d            = PhData;
          end
        end
        PhData: begin
          if (pos_q != 2'd2) begin
            if (!hex[4]) begin
              res_valid_o      = 1'b1;
              res_o.kind       = shfr_pkg::KIND_ERROR;
              res_o.error_code = shfr_pkg::ERR_BAD_HEX;
              do_clear         = 1'b1;
            end else begin
              if (pos_q == 2'd0) begin
                hi_d = hex[3:0];
              end else begin
                lo_d = hex[3:0];
              end
              pos_d = pos_q + 2'd1;
            end
          end else if (rx_byte_i != shfr_pkg::CharLf) begin
            res_valid_o      = 1'b1;
            res_o.kind       = shfr_pkg::KIND_ERROR;
            res_o.error_code = shfr_pkg::ERR_NO_LF;
            do_clear         = 1'b1;
          end else begin
            res_valid_o   = 1'b1;
            res_o.kind    = shfr_pkg::KIND_PAYLOAD;
            res_o.payload = {hi_q, lo_q};
            pos_d         = 2'd0;
            if (left_q <= LB'(1)) begin
              res_o.last = 1'b1;
              do_clear   = 1'b1;
            end else begin
              left_d = left_q - 1'b1;
            end
          end
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
    end

    if (do_clear) begin
      phase_d = (beat_i && phase_q == PhHunt && found_i) ? PhFlag : PhHunt;
      flag_d  = 1'b0;
      acc_d   = '0;
      ovf_d   = 1'b0;
      cnt_d   = '0;
      left_d  = '0;
      hi_d    = 4'b0;
      lo_d    = 4'b0;
      pos_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      flag_q  <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      left_q  <= '0;
      hi_q    <= 4'b0;
      lo_q    <= 4'b0;
      pos_q   <= 2'd0;
      limit_q <= '1;
    end else begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      pos_q   <= pos_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/shfr_out_reg.sv =====
// Result register and stream packing on the master side.
`default_nettype none
module shfr_out_reg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            res_valid_i,
  input  wire shfr_pkg::res_t                  res_i,
  output logic                                 free_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [shfr_pkg::TdataBits-1:0]       m_axis_tdata_o,
  output logic [1:0]                           m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  logic           valid_q, valid_d;
  shfr_pkg::res_t res_q;

  assign free_o  = !valid_q || m_axis_tready_i;
  assign valid_d = res_valid_i || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {4'b0, res_q.error_code, res_q.frame_length,
                            res_q.mode_flag, res_q.payload};
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;

endmodule
`default_nettype wire

// ===== src/sync_hex_frame_receiver_core.sv =====
// Top level of the sync hex frame receiver.
// Takes one received character per beat and accepts a beat every cycle while the
// result register is empty or being drained; each character is handled in the
// cycle it is accepted, and any result (header, payload byte or error) appears on
// the master side in the next cycle. Throughput is one character per cycle, limited
// only by the single result register. The block hunts for "serial sync\n", then
// takes a '0'/'1' flag, a decimal length and that many "HH\n" payload lines.
// length_limit resets to 0xFFFFFF and is written by cfg_we_i/cfg_wdata_i.
// No clearing pass after reset.
`default_nettype none
module sync_hex_frame_receiver_core #(
  parameter int unsigned MAX_DIGITS = 30
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [23:0]                     cfg_wdata_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,   // rx_byte
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // payload[7:0], mode_flag[8], frame_length[32:9], error_code[35:33], zeros
  output logic [shfr_pkg::TdataBits-1:0]       m_axis_tdata_o,
  output logic [1:0]                           m_axis_tuser_o,   // kind
  output logic                                 m_axis_tlast_o
);

  logic           beat;
  logic           found;
  logic           hunting;
  logic           res_valid;
  logic           free;
  shfr_pkg::res_t res;

  assign s_axis_tready_o = free;
  assign beat            = s_axis_tvalid_i && free;

  shfr_sync_detect u_sync (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .hunting_i (hunting),
    .rx_byte_i (s_axis_tdata_i),
    .found_o   (found)
  );

  shfr_parser #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .beat_i      (beat),
    .rx_byte_i   (s_axis_tdata_i),
    .found_i     (found),
    .hunting_o   (hunting),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  shfr_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// ===== src/shfr_checker.sv =====
// Port-level checker for the sync hex frame receiver, bound to the top level.
`default_nettype none
module shfr_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tready_o,
  input wire logic                      m_axis_tvalid_o,
  input wire logic                      m_axis_tready_i,
  input wire logic [shfr_pkg::TdataBits-1:0] m_axis_tdata_o,
  input wire logic [1:0]                m_axis_tuser_o,
  input wire logic                      m_axis_tlast_o
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("result beat changed while stalled");

  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == shfr_pkg::KIND_PAYLOAD))
    else $error("tlast on a non-payload beat");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tuser_o == shfr_pkg::KIND_ERROR) ==
       (m_axis_tdata_o[35:33] != shfr_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  a_header_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == shfr_pkg::KIND_HEADER) |->
      (m_axis_tdata_o[32:9] != 24'd0 && m_axis_tdata_o[7:0] == 8'd0))
    else $error("header with zero length or stray payload");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

endmodule

bind sync_hex_frame_receiver_core shfr_checker u_shfr_checker (.*);
`default_nettype wire
